// ===== design/tlbpt_pkg.sv =====
// tlbpt_pkg: shared widths, constants and controller/datapath handshake types
// for the tlb page table translator; no dependencies

package tlbpt_pkg;

	// address split
	localparam int ADDR_W   = 16;
	localparam int PAGE_W   = 8;
	localparam int OFFSET_W = ADDR_W - PAGE_W;
	localparam int FRAME_W  = 8;

	// page table and frame pool sizes
	localparam int PAGE_COUNT  = 2 ** PAGE_W;
	localparam int FRAME_COUNT = 2 ** FRAME_W;
	localparam int FREE_W      = FRAME_W + 1;

	// running totals
	localparam int CNT_W = 32;

	// stream payload widths
	localparam int S_DATA_W = ADDR_W;
	localparam int M_DATA_W = ADDR_W + 3 * CNT_W;
	localparam int M_USER_W = 3;

	// tuser bit positions on the result side
	localparam int USER_HIT    = 0;
	localparam int USER_FAULT  = 1;
	localparam int USER_NOFREE = 2;

	// controller to datapath commands
	typedef struct packed {
		logic load_addr;
		logic commit_hit;
		logic commit_miss;
	} tlbpt_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic tlb_hit;
	} tlbpt_sts_t;

endpackage

// ===== design/tlbpt_ctrl.sv =====
// tlbpt_ctrl: translation sequencer (idle, tlb lookup, page table walk) and
// result beat valid flag; depends on tlbpt_pkg

module tlbpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  tlbpt_pkg::tlbpt_sts_t sts,
	output tlbpt_pkg::tlbpt_cmd_t cmd
);
	import tlbpt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_WALK   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   m_valid_q;
	logic   out_free;
	logic   commit;

	// result register can take a new beat when empty or draining
	assign out_free = !m_valid_q || m_tready;
	assign commit   = cmd.commit_hit || cmd.commit_miss;
	assign m_tvalid = m_valid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_addr = 1'b1;
					state_nxt     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!sts.tlb_hit) begin
					state_nxt = ST_WALK;
				end else if (out_free) begin
					cmd.commit_hit = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (out_free) begin
					cmd.commit_miss = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/tlbpt_dp.sv =====
// tlbpt_dp: address register, tlb entries with fifo insert pointer, page table
// memory, frame allocator, running totals and result payload; depends on tlbpt_pkg

module tlbpt_dp #(
	parameter int TLB_ENTRIES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tlbpt_pkg::tlbpt_cmd_t           cmd,
	output tlbpt_pkg::tlbpt_sts_t           sts,
	input  logic [tlbpt_pkg::ADDR_W-1:0]    logical_address,
	output logic [tlbpt_pkg::ADDR_W-1:0]    physical_address,
	output logic                            tlb_hit,
	output logic                            page_fault,
	output logic                            no_free_frame,
	output logic [tlbpt_pkg::CNT_W-1:0]     tlb_hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]     fault_total,
	output logic [tlbpt_pkg::CNT_W-1:0]     translation_total
);
	import tlbpt_pkg::*;

	localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

	logic [ADDR_W-1:0]   addr_q;
	logic [PAGE_W-1:0]   page;
	logic [OFFSET_W-1:0] offset;

	logic                tlb_valid_q [TLB_ENTRIES];
	logic [PAGE_W-1:0]   tlb_tag_q   [TLB_ENTRIES];
	logic [FRAME_W-1:0]  tlb_frame_q [TLB_ENTRIES];
	logic [IDX_W-1:0]    ins_ptr_q;

	logic                page_mapped_q [PAGE_COUNT];
	logic [FRAME_W-1:0]  pt_mem [PAGE_COUNT];
	logic [FRAME_W-1:0]  pt_rd_q;
	logic [FREE_W-1:0]   next_free_q;

	logic [CNT_W-1:0]    hit_cnt_q;
	logic [CNT_W-1:0]    fault_cnt_q;
	logic [CNT_W-1:0]    xlat_cnt_q;

	logic [ADDR_W-1:0]   phys_q;
	logic                hit_flag_q;
	logic                fault_flag_q;
	logic                nofree_flag_q;

	logic                match;
	logic [FRAME_W-1:0]  match_frame;
	logic                mapped;
	logic                full;
	logic                fault;
	logic                tlb_wr;
	logic [FRAME_W-1:0]  miss_frame;

	assign page   = addr_q[ADDR_W-1 -: PAGE_W];
	assign offset = addr_q[OFFSET_W-1:0];

	// parallel tag compare, lowest index wins
	always_comb begin
		match       = 1'b0;
		match_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && tlb_tag_q[i] == page) begin
				match       = 1'b1;
				match_frame = tlb_frame_q[i];
			end
		end
	end

	assign sts.tlb_hit = match;

	// miss resolution from page table read and frame allocator
	assign mapped     = page_mapped_q[page];
	assign full       = !mapped && (next_free_q >= FREE_W'(FRAME_COUNT));
	assign fault      = cmd.commit_miss && !mapped && !full;
	assign tlb_wr     = cmd.commit_miss && !full;
	assign miss_frame = mapped ? pt_rd_q : next_free_q[FRAME_W-1:0];

	// address register
	always_ff @(posedge clk) begin
		if (cmd.load_addr) begin
			addr_q <= logical_address;
		end
	end

	// tlb valid bits and fifo insert pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				tlb_valid_q[i] <= 1'b0;
			end
			ins_ptr_q <= '0;
		end else if (tlb_wr) begin
			tlb_valid_q[ins_ptr_q] <= 1'b1;
			if (ins_ptr_q == IDX_W'(TLB_ENTRIES - 1)) begin
				ins_ptr_q <= '0;
			end else begin
				ins_ptr_q <= ins_ptr_q + 1'b1;
			end
		end
	end

	// tlb tag and frame fields
	always_ff @(posedge clk) begin
		if (tlb_wr) begin
			tlb_tag_q[ins_ptr_q]   <= page;
			tlb_frame_q[ins_ptr_q] <= miss_frame;
		end
	end

	// page mapped bits and frame allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAGE_COUNT; i++) begin
				page_mapped_q[i] <= 1'b0;
			end
			next_free_q <= '0;
		end else if (fault) begin
			page_mapped_q[page] <= 1'b1;
			next_free_q         <= next_free_q + 1'b1;
		end
	end

	// page table memory, registered read at the current page
	always_ff @(posedge clk) begin
		if (fault) begin
			pt_mem[page] <= next_free_q[FRAME_W-1:0];
		end
		pt_rd_q <= pt_mem[page];
	end

	// running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			xlat_cnt_q  <= '0;
		end else begin
			if (cmd.commit_hit || cmd.commit_miss) begin
				xlat_cnt_q <= xlat_cnt_q + 1'b1;
			end
			if (cmd.commit_hit) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (fault) begin
				fault_cnt_q <= fault_cnt_q + 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit_hit) begin
			phys_q        <= {match_frame, offset};
			hit_flag_q    <= 1'b1;
			fault_flag_q  <= 1'b0;
			nofree_flag_q <= 1'b0;
		end else if (cmd.commit_miss) begin
			phys_q        <= full ? '0 : {miss_frame, offset};
			hit_flag_q    <= 1'b0;
			fault_flag_q  <= !mapped && !full;
			nofree_flag_q <= full;
		end
	end

	// totals stay put while a beat is held, so they drive the result directly
	assign physical_address  = phys_q;
	assign tlb_hit           = hit_flag_q;
	assign page_fault        = fault_flag_q;
	assign no_free_frame     = nofree_flag_q;
	assign tlb_hit_total     = hit_cnt_q;
	assign fault_total       = fault_cnt_q;
	assign translation_total = xlat_cnt_q;

endmodule

// ===== design/tlb_page_table_translator.sv =====
// tlb_page_table_translator: top level, stream ports around the sequencer
// and the translation datapath; depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_dp

// Translates one 16-bit logical address per beat: the upper 8 bits select a
// page, the lower 8 bits pass through as offset. A TLB hit commits its result
// from the lookup state; a miss commits from the walk state instead, since the
// page table sits in a single-port memory with a registered read that is
// consulted only after the parallel TLB compare. Faulting pages get the next
// frame in order and the TLB refills round robin. The block works on one
// address at a time and takes the next one as soon as the previous result
// sits in the output register; a stalled result adds its wait to the next
// address. Page table mapped bits clear at reset, so no clearing pass is
// needed.

module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// logical_address[15:0]
	input  logic [tlbpt_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// physical_address[15:0], tlb_hit_total[47:16], fault_total[79:48],
	// translation_total[111:80]
	output logic [tlbpt_pkg::M_DATA_W-1:0]    m_tdata,
	// tlb_hit[0], page_fault[1], no_free_frame[2]
	output logic [tlbpt_pkg::M_USER_W-1:0]    m_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready
);
	import tlbpt_pkg::*;

	tlbpt_cmd_t        cmd;
	tlbpt_sts_t        sts;
	logic [ADDR_W-1:0] physical_address;
	logic              tlb_hit;
	logic              page_fault;
	logic              no_free_frame;
	logic [CNT_W-1:0]  tlb_hit_total;
	logic [CNT_W-1:0]  fault_total;
	logic [CNT_W-1:0]  translation_total;

	// sequencer
	tlbpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// translation datapath
	tlbpt_dp #(
		.TLB_ENTRIES (TLB_ENTRIES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.logical_address   (s_tdata[ADDR_W-1:0]),
		.physical_address  (physical_address),
		.tlb_hit           (tlb_hit),
		.page_fault        (page_fault),
		.no_free_frame     (no_free_frame),
		.tlb_hit_total     (tlb_hit_total),
		.fault_total       (fault_total),
		.translation_total (translation_total)
	);

	// result beat packing
	assign m_tdata = {translation_total, fault_total, tlb_hit_total, physical_address};
	assign m_tuser = {no_free_frame, page_fault, tlb_hit};

	// at most one outcome flag per result
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tuser))
		else $error("more than one outcome flag set");

	// exhausted frame pool yields a zero address
	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[USER_NOFREE]) |-> (m_tdata[ADDR_W-1:0] == '0))
		else $error("no_free_frame with nonzero physical address");

	// one address in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("address accepted while another is in flight");

	// a fresh result always counts one more translation
	a_xlat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit_hit || cmd.commit_miss) |=>
		(translation_total == $past(translation_total) + 1'b1))
		else $error("translation total did not advance");

endmodule
